[rtl/core/csn_pkg.sv]
// Package for the subcarrier power normalizer.
// Holds the word types, field widths and register indexes shared by all modules.
// Has no dependencies.
`default_nettype none

package csn_pkg;

    localparam int POWER_W = 16;
    localparam int TOTAL_W = 22;
    localparam int DIV_W   = 22;
    localparam int PROD_W  = POWER_W + DIV_W;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_CARRIER = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MEAN  = 4'd3;

    localparam logic [5:0] BAND_LOW_RST     = 6'd4;
    localparam logic [5:0] BAND_HIGH_RST    = 6'd60;
    localparam logic [5:0] NULL_CARRIER_RST = 6'd32;
    localparam logic [7:0] TARGET_MEAN_RST  = 8'd100;

    localparam logic [7:0] FEATURE_MAX = 8'd255;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    typedef struct packed {
        logic [5:0]        carrier_index;
        logic signed [7:0] in_phase;
        logic signed [7:0] quadrature;
        logic              packet_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0] feature;
        logic [5:0] feature_slot;
        logic       feature_last;
    } t_out_word;

endpackage

`default_nettype wire

[rtl/core/csi_subcarrier_power_normalizer.sv]
// Subcarrier power normalizer. Each accepted I/Q word is taken in the idle
// state; in the load state, if its carrier is kept, its power is written to
// the power store and added to the running total. On the word that ends a
// packet, the numerator state forms the numerator and starts the restoring
// divider, and each feature then passes through store read, multiply,
// saturate and handoff, where o_out_valid waits on i_out_ready. Input is taken
// only while no packet is being processed. The store needs no clearing after reset.
// Depends on csn_pkg, csn_power_mem and csn_divider.
`default_nettype none

module csi_subcarrier_power_normalizer import csn_pkg::*; #(
    parameter int MAX_FEATURES = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire t_cfg_index i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_word   i_in_word,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_word       o_out_word
);

    localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CNT_W  = $clog2(MAX_FEATURES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FEATURES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_NUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_SAT  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]         r_state;
    logic [5:0]         r_band_low;
    logic [5:0]         r_band_high;
    logic [5:0]         r_null_carrier;
    logic [7:0]         r_target;
    t_in_word           r_item;
    logic [CNT_W-1:0]   r_count;
    logic [TOTAL_W-1:0] r_total;
    logic [CNT_W-1:0]   r_k;
    logic [DIV_W-1:0]   r_mult;
    logic [PROD_W-1:0]  r_prod;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic signed [15:0] w_isq;
    logic signed [15:0] w_qsq;
    logic [POWER_W-1:0] w_power;
    logic               w_keep;
    logic [14:0]        w_tc;
    logic [DIV_W-1:0]   w_num;
    logic               w_empty;
    logic               w_div_start;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_div_quo;
    logic [POWER_W-1:0] w_rd_data;
    logic               w_last;

    assign w_isq   = $signed(r_item.in_phase) * $signed(r_item.in_phase);
    assign w_qsq   = $signed(r_item.quadrature) * $signed(r_item.quadrature);
    assign w_power = POWER_W'(w_isq) + POWER_W'(w_qsq);
    assign w_keep  = (r_item.carrier_index >= r_band_low) &&
                     (r_item.carrier_index <= r_band_high) &&
                     (r_item.carrier_index != r_null_carrier) &&
                     (r_count < CNT_MAX);

    assign w_tc        = 15'(r_target) * 15'(r_count);
    assign w_num       = {w_tc[13:0], 8'h00};
    assign w_empty     = (r_count == '0) || (r_total == '0);
    assign w_div_start = (r_state == ST_NUM) && !w_empty;
    assign w_last      = ((r_k + 1'b1) == r_count);

    csn_power_mem #(
        .DEPTH  (MAX_FEATURES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   ((r_state == ST_LOAD) && w_keep),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (w_power),
        .i_rd_en   (r_state == ST_RD),
        .i_rd_addr (r_k[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    csn_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_total),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_low     <= BAND_LOW_RST;
            r_band_high    <= BAND_HIGH_RST;
            r_null_carrier <= NULL_CARRIER_RST;
            r_target       <= TARGET_MEAN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BAND_LOW:     r_band_low     <= i_cfg_data[5:0];
                CFG_BAND_HIGH:    r_band_high    <= i_cfg_data[5:0];
                CFG_NULL_CARRIER: r_null_carrier <= i_cfg_data[5:0];
                CFG_TARGET_MEAN:  r_target       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (w_keep) begin
                        r_count <= r_count + 1'b1;
                        r_total <= r_total + TOTAL_W'(w_power);
                    end
                    r_state <= r_item.packet_end ? ST_NUM : ST_IDLE;
                end
                ST_NUM: begin
                    if (w_empty) begin
                        r_count <= '0;
                        r_total <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_k     <= '0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_SAT;
                end
                ST_SAT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= ST_OUT;
                end
                ST_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_word.feature_last) begin
                            r_count <= '0;
                            r_total <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_item <= i_in_word;
        end
        if ((r_state == ST_DIV) && w_div_done) begin
            r_mult <= w_div_quo;
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(w_rd_data) * PROD_W'(r_mult);
        end
        if (r_state == ST_SAT) begin
            r_out_word.feature      <= (|r_prod[PROD_W-1:16]) ? FEATURE_MAX : r_prod[15:8];
            r_out_word.feature_slot <= 6'(r_k);
            r_out_word.feature_last <= w_last;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

[rtl/core/csn_power_mem.sv]
// Power store: one write port and one read port with registered read data.
// Depends on csn_pkg for the power width.
`default_nettype none

module csn_power_mem import csn_pkg::*; #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_wr_en,
    input  wire logic [ADDR_W-1:0]  i_wr_addr,
    input  wire logic [POWER_W-1:0] i_wr_data,
    input  wire logic               i_rd_en,
    input  wire logic [ADDR_W-1:0]  i_rd_addr,
    output logic [POWER_W-1:0]      o_rd_data
);

    logic [POWER_W-1:0] r_mem [DEPTH];
    logic [POWER_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/core/csn_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
// Depends on csn_pkg for the operand width.
`default_nettype none

module csn_divider import csn_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_num,
    input  wire logic [DIV_W-1:0] i_den,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_step;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W:0]   w_shift;
    logic [DIV_W+1:0] w_diff;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[DIV_W+1]) begin
                r_rem <= w_diff[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire
